// File: rtl/bale_pkg.sv
`timescale 1ns / 1ps

package bale_pkg;

	// List geometry
	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Fixed field widths of the request and result ports
	localparam int OP_W     = 3;
	localparam int DATA_W   = 32;
	localparam int POS_W    = 5;
	localparam int STATUS_W = 3;
	localparam int FOUND_W  = 4;
	localparam int COUNT_W  = 5;

	// Width that holds both a position and a count for compares
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	// Queue between front and back
	localparam int FIFO_DEPTH = 2;
	localparam int FPTR_W     = $clog2(FIFO_DEPTH);
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

	// Request opcodes
	localparam logic [OP_W-1:0] OP_SEARCH    = 3'd0;
	localparam logic [OP_W-1:0] OP_INS_END   = 3'd1;
	localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd2;
	localparam logic [OP_W-1:0] OP_INS_AT    = 3'd3;
	localparam logic [OP_W-1:0] OP_REM_END   = 3'd4;
	localparam logic [OP_W-1:0] OP_REM_FRONT = 3'd5;
	localparam logic [OP_W-1:0] OP_REM_AT    = 3'd6;
	localparam logic [OP_W-1:0] OP_REM_VAL   = 3'd7;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_BADPOS   = 3'd3,
		ST_DUP      = 3'd4,
		ST_NOTFOUND = 3'd5
	} status_t;

	// What a request does to the list
	typedef enum logic [1:0] {
		CLS_SEARCH = 2'd0,
		CLS_INSERT = 2'd1,
		CLS_REMOVE = 2'd2
	} op_class_t;

	// Where in the list it acts
	typedef enum logic [1:0] {
		WH_END   = 2'd0,
		WH_FRONT = 2'd1,
		WH_POS   = 2'd2,
		WH_MATCH = 2'd3
	} where_t;

	// Classified request as it travels from front to back
	typedef struct packed {
		op_class_t                cls;
		where_t                   where;
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]         pos;
	} item_t;

endpackage

// File: rtl/bale_front.sv
`timescale 1ns / 1ps

module bale_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [bale_pkg::OP_W-1:0]             op,
	input  logic signed [bale_pkg::DATA_W-1:0]    value,
	input  logic [bale_pkg::POS_W-1:0]            position,
	input  logic                                  fifo_full,
	output logic                                  busy,
	output logic                                  push,
	output bale_pkg::item_t                       push_item
);

	logic            vld_s1;
	bale_pkg::item_t item_s1;
	bale_pkg::item_t item_dec;
	logic            accept;

	// Hold off a new transfer only while the stage is full and cannot drain
	assign busy   = vld_s1 & fifo_full;
	assign accept = start & ~busy;
	assign push   = vld_s1 & ~fifo_full;
	assign push_item = item_s1;

	// Classify the opcode into kind of change and place in the list
	always_comb begin
		item_dec.value = value;
		item_dec.pos   = position;
		case (op)
			bale_pkg::OP_SEARCH: begin
				item_dec.cls   = bale_pkg::CLS_SEARCH;
				item_dec.where = bale_pkg::WH_MATCH;
			end
			bale_pkg::OP_INS_END: begin
				item_dec.cls   = bale_pkg::CLS_INSERT;
				item_dec.where = bale_pkg::WH_END;
			end
			bale_pkg::OP_INS_FRONT: begin
				item_dec.cls   = bale_pkg::CLS_INSERT;
				item_dec.where = bale_pkg::WH_FRONT;
			end
			bale_pkg::OP_INS_AT: begin
				item_dec.cls   = bale_pkg::CLS_INSERT;
				item_dec.where = bale_pkg::WH_POS;
			end
			bale_pkg::OP_REM_END: begin
				item_dec.cls   = bale_pkg::CLS_REMOVE;
				item_dec.where = bale_pkg::WH_END;
			end
			bale_pkg::OP_REM_FRONT: begin
				item_dec.cls   = bale_pkg::CLS_REMOVE;
				item_dec.where = bale_pkg::WH_FRONT;
			end
			bale_pkg::OP_REM_AT: begin
				item_dec.cls   = bale_pkg::CLS_REMOVE;
				item_dec.where = bale_pkg::WH_POS;
			end
			bale_pkg::OP_REM_VAL: begin
				item_dec.cls   = bale_pkg::CLS_REMOVE;
				item_dec.where = bale_pkg::WH_MATCH;
			end
			default: begin
				item_dec.cls   = bale_pkg::CLS_SEARCH;
				item_dec.where = bale_pkg::WH_MATCH;
			end
		endcase
	end

	// Track stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	// Capture the classified request
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_dec;
		end
	end

endmodule

// File: rtl/bale_fifo.sv
`timescale 1ns / 1ps

module bale_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bale_pkg::item_t push_item,
	input  logic            pop,
	output logic            full,
	output logic            empty,
	output bale_pkg::item_t head
);

	bale_pkg::item_t                entries_q [bale_pkg::FIFO_DEPTH];
	logic [bale_pkg::FPTR_W-1:0]    wr_ptr_q;
	logic [bale_pkg::FPTR_W-1:0]    rd_ptr_q;
	logic [bale_pkg::FCNT_W-1:0]    fill_q;
	logic                           do_push;
	logic                           do_pop;

	assign full    = (fill_q == bale_pkg::FCNT_W'(bale_pkg::FIFO_DEPTH));
	assign empty   = (fill_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign head    = entries_q[rd_ptr_q];

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == bale_pkg::FPTR_W'(bale_pkg::FIFO_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == bale_pkg::FPTR_W'(bale_pkg::FIFO_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// Store the entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// File: rtl/bale_back.sv
`timescale 1ns / 1ps

module bale_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                fifo_empty,
	input  bale_pkg::item_t                     item,
	output logic                                pop,
	output logic                                done,
	output logic [bale_pkg::STATUS_W-1:0]       status,
	output logic [bale_pkg::FOUND_W-1:0]        found_index,
	output logic [bale_pkg::COUNT_W-1:0]        entry_count
);

	logic [bale_pkg::DATA_W-1:0] store_q   [bale_pkg::CAPACITY];
	logic [bale_pkg::DATA_W-1:0] store_nxt [bale_pkg::CAPACITY];
	logic [bale_pkg::DATA_W-1:0] shift_up  [bale_pkg::CAPACITY];
	logic [bale_pkg::DATA_W-1:0] shift_dn  [bale_pkg::CAPACITY];
	logic [bale_pkg::CNT_W-1:0]  count_q;
	logic [bale_pkg::CNT_W-1:0]  count_nxt;
	logic [bale_pkg::CAPACITY-1:0] match;
	logic                        hit;
	logic [bale_pkg::IDX_W-1:0]  first;
	logic [bale_pkg::CMP_W-1:0]  at;
	logic [bale_pkg::CMP_W-1:0]  cnt_ext;
	logic [bale_pkg::CMP_W-1:0]  pos_ext;
	logic                        do_ins;
	logic                        do_rem;
	bale_pkg::status_t           st;
	logic [bale_pkg::IDX_W-1:0]  idx_out;

	logic                        done_q;
	bale_pkg::status_t           status_q;
	logic [bale_pkg::FOUND_W-1:0] found_q;
	logic [bale_pkg::COUNT_W-1:0] count_out_q;

	// The back end never stalls: take the queue head whenever one is there
	assign pop = ~fifo_empty;

	assign cnt_ext = bale_pkg::CMP_W'(count_q);
	assign pos_ext = bale_pkg::CMP_W'(item.pos);

	// Compare every live entry against the value and pick the first hit
	always_comb begin
		for (int i = 0; i < bale_pkg::CAPACITY; i++) begin
			match[i] = (bale_pkg::CNT_W'(i) < count_q) && (store_q[i] == item.value);
		end
		hit   = |match;
		first = '0;
		for (int i = bale_pkg::CAPACITY - 1; i >= 0; i--) begin
			if (match[i]) begin
				first = bale_pkg::IDX_W'(i);
			end
		end
	end

	// Select the slot the request acts on
	always_comb begin
		case (item.where)
			bale_pkg::WH_END:   at = (item.cls == bale_pkg::CLS_INSERT) ? cnt_ext : cnt_ext - 1'b1;
			bale_pkg::WH_FRONT: at = '0;
			bale_pkg::WH_POS:   at = pos_ext;
			bale_pkg::WH_MATCH: at = bale_pkg::CMP_W'(first);
			default:            at = '0;
		endcase
	end

	// Decide the outcome
	always_comb begin
		st      = bale_pkg::ST_OK;
		do_ins  = 1'b0;
		do_rem  = 1'b0;
		idx_out = '0;
		case (item.cls)
			bale_pkg::CLS_SEARCH: begin
				if (hit) begin
					idx_out = first;
				end else begin
					st = bale_pkg::ST_NOTFOUND;
				end
			end
			bale_pkg::CLS_INSERT: begin
				if (count_q == bale_pkg::CNT_W'(bale_pkg::CAPACITY)) begin
					st = bale_pkg::ST_FULL;
				end else if (item.where == bale_pkg::WH_POS && pos_ext > cnt_ext) begin
					st = bale_pkg::ST_BADPOS;
				end else if (hit) begin
					st = bale_pkg::ST_DUP;
				end else begin
					do_ins = 1'b1;
				end
			end
			bale_pkg::CLS_REMOVE: begin
				if (count_q == '0) begin
					st = bale_pkg::ST_EMPTY;
				end else if (item.where == bale_pkg::WH_POS && pos_ext >= cnt_ext) begin
					st = bale_pkg::ST_BADPOS;
				end else if (item.where == bale_pkg::WH_MATCH && !hit) begin
					st = bale_pkg::ST_NOTFOUND;
				end else begin
					do_rem = 1'b1;
				end
			end
			default: begin
				st = bale_pkg::ST_NOTFOUND;
			end
		endcase
	end

	// Build the neighbor views used for shifting
	always_comb begin
		shift_up[0] = '0;
		for (int i = 1; i < bale_pkg::CAPACITY; i++) begin
			shift_up[i] = store_q[i-1];
		end
		shift_dn[bale_pkg::CAPACITY-1] = '0;
		for (int i = 0; i < bale_pkg::CAPACITY - 1; i++) begin
			shift_dn[i] = store_q[i+1];
		end
	end

	// Per-cell next value: open a slot or close one; slots past the count stay zero
	always_comb begin
		for (int i = 0; i < bale_pkg::CAPACITY; i++) begin
			if (do_ins && bale_pkg::CMP_W'(i) == at) begin
				store_nxt[i] = item.value;
			end else if (do_ins && bale_pkg::CMP_W'(i) > at) begin
				store_nxt[i] = shift_up[i];
			end else if (do_rem && bale_pkg::CMP_W'(i) >= at) begin
				store_nxt[i] = shift_dn[i];
			end else begin
				store_nxt[i] = store_q[i];
			end
		end
		if (do_ins) begin
			count_nxt = count_q + 1'b1;
		end else if (do_rem) begin
			count_nxt = count_q - 1'b1;
		end else begin
			count_nxt = count_q;
		end
	end

	// Update the list and register the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bale_pkg::CAPACITY; i++) begin
				store_q[i] <= '0;
			end
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= pop;
			if (pop) begin
				for (int i = 0; i < bale_pkg::CAPACITY; i++) begin
					store_q[i] <= store_nxt[i];
				end
				count_q <= count_nxt;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			status_q    <= st;
			found_q     <= bale_pkg::FOUND_W'(idx_out);
			count_out_q <= bale_pkg::COUNT_W'(count_nxt);
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign found_index = found_q;
	assign entry_count = count_out_q;

endmodule

// File: rtl/bounded_array_list_engine.sv
`timescale 1ns / 1ps

// Ordered list of up to bale_pkg::CAPACITY signed words with search, insert and
// remove requests. A request transfers when start is high and busy is low; its
// result is driven on status, found_index and entry_count for exactly one cycle
// with done high, once the request has passed the front stage register, a queue
// entry and the back end's result register. The receiver cannot stall
// results. The front end classifies each request and hands it through a
// two-entry queue to the back end, which compares all entries in parallel and
// shifts every cell in the same cycle, so a new request is taken every cycle
// and busy stays low in normal operation. The list and count reset to zero.
module bounded_array_list_engine (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [bale_pkg::OP_W-1:0]             op,
	input  logic signed [bale_pkg::DATA_W-1:0]    value,
	input  logic [bale_pkg::POS_W-1:0]            position,
	output logic                                  done,
	output logic [bale_pkg::STATUS_W-1:0]         status,
	output logic [bale_pkg::FOUND_W-1:0]          found_index,
	output logic [bale_pkg::COUNT_W-1:0]          entry_count
);

	logic            push;
	bale_pkg::item_t push_item;
	logic            fifo_full;
	logic            fifo_empty;
	logic            pop;
	bale_pkg::item_t head;

	// Accept and classify requests
	bale_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.op        (op),
		.value     (value),
		.position  (position),
		.fifo_full (fifo_full),
		.busy      (busy),
		.push      (push),
		.push_item (push_item)
	);

	// Decouple front from back
	bale_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (fifo_full),
		.empty     (fifo_empty),
		.head      (head)
	);

	// Execute against the list
	bale_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.fifo_empty  (fifo_empty),
		.item        (head),
		.pop         (pop),
		.done        (done),
		.status      (status),
		.found_index (found_index),
		.entry_count (entry_count)
	);

endmodule

// File: rtl/bale_checker.sv
`timescale 1ns / 1ps

module bale_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  start,
	input logic                                  busy,
	input logic [bale_pkg::OP_W-1:0]             op,
	input logic signed [bale_pkg::DATA_W-1:0]    value,
	input logic [bale_pkg::POS_W-1:0]            position,
	input logic                                  done,
	input logic [bale_pkg::STATUS_W-1:0]         status,
	input logic [bale_pkg::FOUND_W-1:0]          found_index,
	input logic [bale_pkg::COUNT_W-1:0]          entry_count
);

	// Every transfer is followed by its result with done high
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("result missing three cycles after transfer");

	// No result without a matching earlier transfer
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("result without matching transfer");

	// Full refusal only with a full list, empty refusal only with an empty one
	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((status != bale_pkg::ST_FULL ||
			entry_count == bale_pkg::COUNT_W'(bale_pkg::CAPACITY)) &&
			(status != bale_pkg::ST_EMPTY || entry_count == '0)))
		else $error("full or empty status disagrees with count");

	// A nonzero index only comes with a successful request
	a_index_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found_index != '0) |-> (status == bale_pkg::ST_OK))
		else $error("found index set on failed request");

	// Count never exceeds the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($unsigned(entry_count) <= bale_pkg::CAPACITY))
		else $error("entry count above capacity");

endmodule

bind bounded_array_list_engine bale_checker u_bale_checker (.*);

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
	import bale_pkg::*;

	localparam int TOTAL_ITEMS  = 1450;
	localparam int GAP_LIGHT    = 27;
	localparam int GAP_HEAVY    = 68;
	localparam int SEGMENT_LEN  = 48;
	localparam int POOL_SIZE    = 20;
	localparam int BIAS_PCT     = 70;
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int REPORT_LIMIT = 10;

	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] VAL_NEG = 32'hFFFF_FFFF;

	typedef enum int {
		MIX_FILL,
		MIX_DRAIN,
		MIX_ANY
	} mix_t;

	typedef struct {
		logic [OP_W-1:0]          op;
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]         position;
		int unsigned              gap_pct;
	} list_request_t;

	typedef struct {
		status_t              status;
		logic [FOUND_W-1:0]   found_index;
		logic [COUNT_W-1:0]   entry_count;
	} list_result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [OP_W-1:0]          op;
	logic signed [DATA_W-1:0] value;
	logic [POS_W-1:0]         position;
	logic                     done;
	logic [STATUS_W-1:0]      status;
	logic [FOUND_W-1:0]       found_index;
	logic [COUNT_W-1:0]       entry_count;

	// Shadow copy of the list
	logic signed [DATA_W-1:0] shadow_list [CAPACITY];
	int                       shadow_count;

	list_request_t request_queue [$];
	list_result_t  pending_results [$];
	int            queued_total;
	int            accepted_count;
	int            mismatch_count;
	int            cycle_count;
	bit            took;

	bounded_array_list_engine u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.value       (value),
		.position    (position),
		.done        (done),
		.status      (status),
		.found_index (found_index),
		.entry_count (entry_count)
	);

	always #5 clk = ~clk;

	// Apply one request to the shadow list and return the result it yields
	function automatic list_result_t apply_list_op(input logic [OP_W-1:0] opc,
		input logic signed [DATA_W-1:0] val, input logic [POS_W-1:0] pos);
		list_result_t res;
		int hit;
		int at;
		int i;
		res.status = ST_OK;
		res.found_index = '0;
		hit = -1;
		for (i = shadow_count - 1; i >= 0; i--) begin
			if (shadow_list[i] == val)
				hit = i;
		end
		case (opc)
			OP_SEARCH: begin
				if (hit >= 0)
					res.found_index = FOUND_W'(hit);
				else
					res.status = ST_NOTFOUND;
			end
			OP_INS_END, OP_INS_FRONT, OP_INS_AT: begin
				if (shadow_count >= CAPACITY) begin
					res.status = ST_FULL;
				end else if (opc == OP_INS_AT && int'(pos) > shadow_count) begin
					res.status = ST_BADPOS;
				end else if (hit >= 0) begin
					res.status = ST_DUP;
				end else begin
					at = (opc == OP_INS_END) ? shadow_count :
						(opc == OP_INS_FRONT) ? 0 : int'(pos);
					for (i = shadow_count; i > at; i--)
						shadow_list[i] = shadow_list[i-1];
					shadow_list[at] = val;
					shadow_count++;
				end
			end
			default: begin
				if (shadow_count == 0) begin
					res.status = ST_EMPTY;
				end else if (opc == OP_REM_AT && int'(pos) >= shadow_count) begin
					res.status = ST_BADPOS;
				end else if (opc == OP_REM_VAL && hit < 0) begin
					res.status = ST_NOTFOUND;
				end else begin
					at = (opc == OP_REM_END) ? shadow_count - 1 :
						(opc == OP_REM_FRONT) ? 0 :
						(opc == OP_REM_AT) ? int'(pos) : hit;
					for (i = at; i + 1 < shadow_count; i++)
						shadow_list[i] = shadow_list[i+1];
					shadow_list[shadow_count-1] = '0;
					shadow_count--;
				end
			end
		endcase
		res.entry_count = COUNT_W'(shadow_count);
		return res;
	endfunction

	// Append a request; the sender gap rate follows its place in the run
	function automatic void queue_request(input logic [OP_W-1:0] opc,
		input logic signed [DATA_W-1:0] val, input logic [POS_W-1:0] pos);
		list_request_t req;
		req.op = opc;
		req.value = val;
		req.position = pos;
		req.gap_pct = (queued_total < TOTAL_ITEMS / 3) ? GAP_LIGHT :
			(queued_total < 2 * TOTAL_ITEMS / 3) ? GAP_HEAVY : 0;
		request_queue.push_back(req);
		queued_total++;
	endfunction

	function automatic void note_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("%0t: mismatch: %s", $realtime, what);
	endfunction

	// Present the next request once the previous one has transferred
	always @(negedge clk) begin : request_drive
		list_request_t nxt;
		if (arst_n && (!start || took)) begin
			if (request_queue.size() != 0 &&
				$urandom_range(99) >= request_queue[0].gap_pct) begin
				nxt = request_queue.pop_front();
				op       <= nxt.op;
				value    <= nxt.value;
				position <= nxt.position;
				start    <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Check each result against the oldest expectation, then predict the new transfer
	always @(posedge clk) begin : result_check
		list_result_t want;
		took = 1'b0;
		if (arst_n) begin
			if (done) begin
				if (pending_results.size() == 0) begin
					note_mismatch($sformatf("unexpected result status=%0d index=%0d count=%0d",
						status, found_index, entry_count));
				end else begin
					want = pending_results.pop_front();
					if (status !== want.status || found_index !== want.found_index ||
						entry_count !== want.entry_count)
						note_mismatch($sformatf({"status exp %0d got %0d, index exp %0d got %0d, ",
							"count exp %0d got %0d"}, want.status, status, want.found_index,
							found_index, want.entry_count, entry_count));
				end
			end
			if (start && !busy) begin
				took = 1'b1;
				pending_results.push_back(apply_list_op(op, value, position));
				accepted_count++;
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		logic signed [DATA_W-1:0] pool [POOL_SIZE];
		mix_t                     mix;
		logic [OP_W-1:0]          opc;
		logic signed [DATA_W-1:0] val;
		logic [POS_W-1:0]         pos;
		int                       n;
		int                       roll;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		op = OP_SEARCH;
		value = '0;
		position = '0;
		queued_total = 0;
		accepted_count = 0;
		mismatch_count = 0;
		cycle_count = 0;
		shadow_count = 0;
		foreach (shadow_list[i])
			shadow_list[i] = '0;

		// Empty list: search misses, every remove reports empty
		queue_request(OP_SEARCH, 32'sd5, 5'd0);
		queue_request(OP_REM_END, '0, 5'd0);
		queue_request(OP_REM_FRONT, '0, 5'd0);
		queue_request(OP_REM_AT, '0, 5'd0);
		queue_request(OP_REM_VAL, 32'sd5, 5'd0);
		// Build the list with extreme values, then refused inserts
		queue_request(OP_INS_END, VAL_MAX, 5'd0);
		queue_request(OP_INS_FRONT, VAL_MIN, 5'd0);
		queue_request(OP_INS_AT, '0, 5'd1);
		queue_request(OP_INS_AT, 32'sd7, 5'd4);
		queue_request(OP_INS_END, VAL_MIN, 5'd0);
		queue_request(OP_INS_AT, VAL_NEG, 5'd3);
		queue_request(OP_SEARCH, VAL_NEG, 5'd0);
		queue_request(OP_SEARCH, VAL_MIN, 5'd0);
		// Positions at and past the count
		queue_request(OP_REM_AT, '0, 5'd4);
		queue_request(OP_REM_AT, '0, 5'd31);
		queue_request(OP_INS_AT, 32'sd9, 5'd31);
		queue_request(OP_REM_VAL, 32'sd12345, 5'd0);
		// Drain through each remove flavor
		queue_request(OP_REM_VAL, '0, 5'd0);
		queue_request(OP_REM_FRONT, '0, 5'd0);
		queue_request(OP_REM_END, '0, 5'd0);
		queue_request(OP_REM_AT, '0, 5'd0);
		queue_request(OP_SEARCH, '0, 5'd0);

		// Random part: values mostly from a small pool so hits and duplicates occur
		foreach (pool[i])
			pool[i] = $urandom;
		mix = MIX_ANY;
		for (n = 0; queued_total < TOTAL_ITEMS; n++) begin
			if (n % SEGMENT_LEN == 0) begin
				mix = mix_t'($urandom_range(MIX_ANY));
				pool[$urandom_range(POOL_SIZE - 1)] = $urandom;
			end
			roll = $urandom_range(99);
			if (mix == MIX_FILL && roll < BIAS_PCT)
				opc = OP_W'($urandom_range(OP_INS_AT, OP_INS_END));
			else if (mix == MIX_DRAIN && roll < BIAS_PCT)
				opc = OP_W'($urandom_range(OP_REM_VAL, OP_REM_END));
			else
				opc = OP_W'($urandom_range(OP_REM_VAL));
			roll = $urandom_range(99);
			if (roll < 75)
				val = pool[$urandom_range(POOL_SIZE - 1)];
			else if (roll < 78)
				val = VAL_MIN;
			else if (roll < 81)
				val = VAL_MAX;
			else if (roll < 84)
				val = VAL_NEG;
			else if (roll < 87)
				val = '0;
			else
				val = $urandom;
			if ($urandom_range(99) < 85)
				pos = POS_W'($urandom_range(CAPACITY));
			else
				pos = POS_W'($urandom_range(31));
			queue_request(opc, val, pos);
		end

		// Hold reset, release it away from the rising edge
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait for every transfer and its result, then let the pipeline settle
		while (accepted_count < queued_total || pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
